// ===== hdl/lru_page_replacement_top_assert.svh =====
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication
`define LRUPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Sizes, types and helpers shared by the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int NUM_FRAMES = 8;
  localparam int PAGE_BITS  = 16;

  localparam int SLOT_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SLOT_W-1:0]    rank_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]     count_t;

  localparam rank_t RANK_MAX = rank_t'(NUM_FRAMES - 1);

  // running search result handed from cell to cell
  typedef struct packed {
    slot_t idx;
    logic  hit;
    slot_t hit_slot;
    rank_t hit_rank;
    logic  empty;
    slot_t empty_slot;
    logic  have_best;
    rank_t best_rank;
    slot_t best_slot;
    page_t best_page;
  } search_t;

  // lookup key and update command broadcast to every cell
  typedef struct packed {
    page_t  page;
    count_t count;
    logic   en;
    logic   hit;
    slot_t  slot;
    rank_t  limit;
    logic   clear;
  } cmd_t;

  function automatic count_t active_count(logic [3:0] cfg);
    count_t c;
    if (cfg == 4'd0) begin
      c = count_t'(1);
    end else if (int'(cfg) > NUM_FRAMES) begin
      c = count_t'(NUM_FRAMES);
    end else begin
      c = count_t'(cfg);
    end
    return c;
  endfunction

endpackage

// ===== hdl/lrupr_if.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement channels
// Request, response and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
interface lrupr_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] page_number;
  logic        last_reference;

  modport source (output valid, page_number, last_reference, input ready);
  modport sink   (input valid, page_number, last_reference, output ready);
endinterface

interface lrupr_rsp_if;
  logic        valid;
  logic        ready;
  logic        is_fault;
  logic [2:0]  frame_slot;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [15:0] fault_total;
  logic        trace_end;

  modport source (output valid, is_fault, frame_slot, evicted_valid, evicted_page,
                  fault_total, trace_end, input ready);
  modport sink   (input valid, is_fault, frame_slot, evicted_valid, evicted_page,
                  fault_total, trace_end, output ready);
  modport mon    (input valid, ready, is_fault, frame_slot, evicted_valid, evicted_page,
                  fault_total, trace_end);
endinterface

interface lrupr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell
// One page frame: page, valid and recency rank, plus its link of the search
// chain (first hit, first empty frame, oldest frame so far).
// ----------------------------------------------------------------------------
module lrupr_cell (
  input  logic              clk,
  input  logic              rst,
  input  lrupr_pkg::cmd_t    cmd,
  input  lrupr_pkg::search_t prev,
  output lrupr_pkg::search_t next
);
  import lrupr_pkg::*;

  page_t page;
  logic  valid;
  rank_t rank;

  logic active;
  logic match;
  logic sel;
  logic age;

  assign active = count_t'(prev.idx) < cmd.count;
  assign match  = active && valid && (page == cmd.page);
  assign sel    = (prev.idx == cmd.slot);
  // hit ages only frames newer than the hit frame; a fault ages all other valid frames
  assign age    = active && valid && !sel && (rank < RANK_MAX) &&
                  (!cmd.hit || (rank < cmd.limit));

  always_comb begin
    next     = prev;
    next.idx = prev.idx + slot_t'(1);
    if (match && !prev.hit) begin
      next.hit      = 1'b1;
      next.hit_slot = prev.idx;
      next.hit_rank = rank;
    end
    if (active && !valid && !prev.empty) begin
      next.empty      = 1'b1;
      next.empty_slot = prev.idx;
    end
    // strictly greater keeps ties on the lower frame
    if (active && (!prev.have_best || (rank > prev.best_rank))) begin
      next.have_best = 1'b1;
      next.best_rank = rank;
      next.best_slot = prev.idx;
      next.best_page = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.en) begin
      if (cmd.clear) begin
        valid <= 1'b0;
        rank  <= '0;
      end else if (sel) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (age) begin
        rank <= rank + rank_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && sel) begin
      page <= cmd.page;
    end
  end

endmodule

// ===== hdl/lru_page_replacement_top.sv =====
// Flow: a request is taken into the holding stage, and its result is registered into
// the response register once that register is free or being drained.
// Throughput: one reference per cycle while the response side keeps up; the
// search through the row of frame cells is combinational.
// Reset: all frames empty, ranks and fault count zero, frames_in_use = 8.
// No clearing pass; frame pages are written before they are ever read.
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// LRU page frame set: holding stage, chain of frame cells, response register.
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
  input logic         clk,
  input logic         rst,
  lrupr_req_if.sink   req,
  lrupr_rsp_if.source rsp,
  lrupr_cfg_if.sink   cfg
);
  import lrupr_pkg::*;

  logic [3:0]  frames_in_use;
  logic        req_full;
  page_t       req_page;
  logic        req_last;
  logic [15:0] fault_counter;
  logic [15:0] fault_counter_next;

  logic    step;
  logic    is_fault;
  logic    evict;
  slot_t   slot;
  cmd_t    cmd;
  search_t chain [NUM_FRAMES+1];
  search_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 4'd8;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.data;
    end
  end

  // update happens when the response register is free or being drained
  assign step      = req_full && (!rsp.valid || rsp.ready);
  assign req.ready = !req_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req.ready) begin
      req_full <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_page <= page_t'(req.page_number);
      req_last <= req.last_reference;
    end
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lrupr_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .prev (chain[g]),
      .next (chain[g+1])
    );
  end

  assign res      = chain[NUM_FRAMES];
  assign is_fault = !res.hit;
  assign evict    = !res.hit && !res.empty;

  always_comb begin
    if (res.hit) begin
      slot = res.hit_slot;
    end else if (res.empty) begin
      slot = res.empty_slot;
    end else begin
      slot = res.best_slot;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.page  = req_page;
    cmd.count = active_count(frames_in_use);
    cmd.en    = step;
    cmd.hit   = res.hit;
    cmd.slot  = slot;
    cmd.limit = res.hit_rank;
    cmd.clear = req_last;
  end

  always_comb begin
    fault_counter_next = fault_counter;
    if (is_fault && (fault_counter != 16'hFFFF)) begin
      fault_counter_next = fault_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_counter <= '0;
    end else if (step) begin
      fault_counter <= req_last ? 16'd0 : fault_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (step) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.is_fault      <= is_fault;
      rsp.frame_slot    <= 3'(slot);
      rsp.evicted_valid <= evict;
      rsp.evicted_page  <= evict ? 16'(res.best_page) : 16'd0;
      rsp.fault_total   <= fault_counter_next;
      rsp.trace_end     <= req_last;
    end
  end

endmodule

// ===== hdl/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_top_assert.svh"

module lrupr_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        is_fault,
  input logic [2:0]  frame_slot,
  input logic        evicted_valid,
  input logic [15:0] evicted_page,
  input logic [15:0] fault_total,
  input logic        trace_end
);
  import lrupr_pkg::*;

  logic        stalled;
  logic        evicting;
  logic        no_evict;
  logic        fault_seen;
  logic [37:0] payload;

  assign stalled    = valid && !ready;
  assign evicting   = valid && evicted_valid;
  assign no_evict   = valid && !evicted_valid;
  assign fault_seen = valid && is_fault;
  assign payload = {is_fault, frame_slot, evicted_valid, evicted_page, fault_total, trace_end};

  `LRUPR_ASSERT_NEXT(a_rsp_hold, clk, rst, stalled, valid && $stable(payload), "response not held")
  `LRUPR_ASSERT_NOW(a_hit_no_evict, clk, rst, evicting, is_fault, "eviction on a hit")
  `LRUPR_ASSERT_NOW(a_evict_zero, clk, rst, no_evict, evicted_page == '0, "stray evicted page")
  `LRUPR_ASSERT_NOW(a_fault_count, clk, rst, fault_seen, fault_total != '0, "zero fault total")

endmodule

bind lru_page_replacement_top lrupr_checker u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (rsp.valid),
  .ready         (rsp.ready),
  .is_fault      (rsp.is_fault),
  .frame_slot    (rsp.frame_slot),
  .evicted_valid (rsp.evicted_valid),
  .evicted_page  (rsp.evicted_page),
  .fault_total   (rsp.fault_total),
  .trace_end     (rsp.trace_end)
);
